>>> design/lav_pkg.sv
// shared types and constants for the look-at view matrix core
`default_nettype none
package lav_pkg;

	localparam int W = 32;

	// front-end job: eye point, forward difference and up vector
	typedef struct packed {
		logic signed [W-1:0] ex, ey, ez;
		logic signed [W:0]   dx, dy, dz;
		logic signed [W-1:0] ux, uy, uz;
	} lav_job_t;

	// finished result row
	typedef struct packed {
		logic [1:0]          row;
		logic signed [W-1:0] c0, c1, c2, c3;
		logic                degen;
		logic                last;
	} lav_row_t;

	// sequencer states of the back end
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_NORM  = 8'b0000_0010,
		ST_SQRT  = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_CROSS = 8'b0001_0000,
		ST_DOT   = 8'b0010_0000,
		ST_EMIT  = 8'b0100_0000,
		ST_NEXT  = 8'b1000_0000
	} lav_state_t;

endpackage
`default_nettype wire

>>> design/lav_queue.sv
// short job queue between front end and back end
`default_nettype none
module lav_queue import lav_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr_valid,
	output logic          wr_ready,
	input  wire lav_job_t wr_data,
	output logic          rd_valid,
	input  wire logic     rd_ready,
	output lav_job_t      rd_data
);
	lav_job_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];

	// two-entry storage
	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((wr_valid && wr_ready) ? 1 : 0)
			               - 2'((rd_valid && rd_ready) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

>>> design/lav_back.sv
// back end: normalisation, cross products and translation per job
`default_nettype none
module lav_back import lav_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     job_valid,
	output logic          job_ready,
	input  wire lav_job_t job,
	output logic          row_valid,
	input  wire logic     row_ready,
	output lav_row_t      row_out
);
	localparam int RW = FRAC_BITS + 32;

	lav_state_t          st_q;
	lav_job_t            job_q;
	logic                which_q;      // 0 forward, 1 up
	logic [32:0]         m_q [3];
	logic                sg_q [3];
	logic [63:0]         s_q, x_q, res_q, bit_q;
	logic [31:0]         r_q;
	logic [1:0]          ci_q;
	logic [RW-1:0]       rem_q, quo_q;
	logic [6:0]          bc_q;
	logic signed [33:0]  f_q [3];
	logic signed [33:0]  u_q [3];
	logic signed [33:0]  rows_q [3][3];
	logic [1:0]          k_q;
	logic [1:0]          step_q;
	logic                degen_q;
	logic signed [31:0]  t_q;
	logic signed [63:0]  acc_q;
	logic                out_v_q;
	lav_row_t            out_q;

	assign job_ready = (st_q == ST_IDLE);
	assign row_valid = out_v_q;
	assign row_out   = out_q;

	// magnitude and sign of the selected vector
	logic [32:0] ma [3];
	logic        sa [3];
	always_comb begin
		logic signed [32:0] v [3];
		if (!which_q) begin
			v[0] = job_q.dx; v[1] = job_q.dy; v[2] = job_q.dz;
		end else begin
			v[0] = 33'(job_q.ux); v[1] = 33'(job_q.uy); v[2] = 33'(job_q.uz);
		end
		for (int i = 0; i < 3; i++) begin
			sa[i] = v[i][32];
			ma[i] = v[i][32] ? 33'(-v[i]) : 33'(v[i]);
		end
	end

	// round to nearest, ties away, then saturate
	function automatic logic signed [31:0] rsat(input logic signed [63:0] x);
		logic [63:0] m;
		logic signed [64:0] r;
		m = x[63] ? 64'(-x) : 64'(x);
		m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		r = x[63] ? -$signed({1'b0, m}) : $signed({1'b0, m});
		if (r > 65'sd2147483647) return 32'sh7fffffff;
		if (r < -65'sd2147483648) return 32'sh80000000;
		return 32'(r);
	endfunction

	logic [32:0] mx;
	assign mx = (ma[0] > ma[1]) ? ((ma[0] > ma[2]) ? ma[0] : ma[2])
	                            : ((ma[1] > ma[2]) ? ma[1] : ma[2]);

	logic [63:0] sq;
	assign sq = 64'(m_q[ci_q]) * 64'(m_q[ci_q]);

	logic [RW:0] rem_sh;
	assign rem_sh = {rem_q, quo_q[RW-1]};

	// cross-product operands for the current step
	logic signed [33:0] ca [3], cb [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ca[i] = (k_q == 2'd0) ? f_q[i] : rows_q[0][i];
			cb[i] = (k_q == 2'd0) ? u_q[i] : f_q[i];
		end
	end
	logic [1:0] i1, i2;
	assign i1 = (step_q == 2'd2) ? 2'd0 : step_q + 2'd1;
	assign i2 = (step_q == 2'd0) ? 2'd2 : step_q - 2'd1;
	logic signed [63:0] p1, p2;
	assign p1 = 64'(ca[i1]) * 64'(cb[i2]);
	assign p2 = 64'(ca[i2]) * 64'(cb[i1]);
	logic signed [63:0] pe;
	always_comb begin
		logic signed [31:0] e;
		case (step_q)
			2'd0:    e = job_q.ex;
			2'd1:    e = job_q.ey;
			default: e = job_q.ez;
		endcase
		pe = 64'(rows_q[k_q][step_q]) * 64'(e);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_v_q <= 1'b0;
		end else begin
			if (row_valid && row_ready && st_q != ST_EMIT) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (job_valid) begin
					job_q <= job; which_q <= 1'b0; st_q <= ST_NORM;
				end
				ST_NORM: begin
					if (mx == 33'd0) begin
						degen_q <= 1'b1; k_q <= 2'd0; st_q <= ST_EMIT;
						for (int a = 0; a < 3; a++)
							for (int b = 0; b < 3; b++) rows_q[a][b] <= '0;
					end else begin
						for (int i = 0; i < 3; i++) begin
							sg_q[i] <= sa[i];
							if (mx[32] || mx[31]) m_q[i] <= ma[i] >> (mx[32] ? 2 : 1);
							else m_q[i] <= ma[i];
						end
						degen_q <= 1'b0; s_q <= '0; ci_q <= 2'd0; st_q <= ST_SQRT;
						bit_q <= 64'd0;
					end
				end
				ST_SQRT: begin
					// left shift up to [2^30,2^31), then sum squares, then isqrt
					if (!m_q[0][30] && !m_q[1][30] && !m_q[2][30] && bit_q == 0
					    && ci_q == 2'd0 && s_q == 0) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else if (bit_q == 0 && ci_q != 2'd3) begin
						s_q <= s_q + sq;
						if (ci_q == 2'd2) begin
							ci_q <= 2'd3; bit_q <= 64'd1 << 62;
						end else ci_q <= ci_q + 2'd1;
						x_q <= s_q + sq; res_q <= '0;
					end else if (bit_q != 0) begin
						if (x_q >= res_q + bit_q) begin
							x_q <= x_q - (res_q + bit_q);
							res_q <= (res_q >> 1) + bit_q;
						end else res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
					end else begin
						r_q <= 32'(res_q);
						ci_q <= 2'd0; bc_q <= '0; rem_q <= '0;
						quo_q <= RW'({m_q[0][31:0], FRAC_BITS'(0)}) + RW'(res_q >> 1);
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (bc_q != 7'(RW)) begin
						if (rem_sh >= (RW+1)'(r_q)) begin
							rem_q <= RW'(rem_sh - (RW+1)'(r_q));
							quo_q <= {quo_q[RW-2:0], 1'b1};
						end else begin
							rem_q <= RW'(rem_sh);
							quo_q <= {quo_q[RW-2:0], 1'b0};
						end
						bc_q <= bc_q + 7'd1;
					end else begin
						if (!which_q)
							f_q[ci_q] <= sg_q[ci_q] ? -34'(quo_q) : 34'(quo_q);
						else
							u_q[ci_q] <= sg_q[ci_q] ? -34'(quo_q) : 34'(quo_q);
						bc_q <= '0; rem_q <= '0;
						if (ci_q == 2'd2) begin
							if (!which_q) begin
								which_q <= 1'b1; st_q <= ST_NORM;
							end else begin
								k_q <= 2'd0; step_q <= 2'd0; st_q <= ST_CROSS;
							end
						end else begin
							ci_q <= ci_q + 2'd1;
							quo_q <= RW'({m_q[ci_q+2'd1][31:0], FRAC_BITS'(0)})
							         + RW'(r_q >> 1);
						end
					end
				end
				ST_CROSS: begin
					rows_q[k_q][step_q] <= 34'(rsat(p1 - p2));
					if (step_q == 2'd2) begin
						step_q <= 2'd0;
						if (k_q == 2'd1) begin
							for (int i = 0; i < 3; i++) rows_q[2][i] <= -f_q[i];
							k_q <= 2'd0; acc_q <= '0; st_q <= ST_DOT;
						end else k_q <= 2'd1;
					end else step_q <= step_q + 2'd1;
				end
				ST_DOT: begin
					if (step_q == 2'd3) begin
						t_q <= rsat(-acc_q); st_q <= ST_EMIT;
					end else begin
						acc_q <= acc_q + pe; step_q <= step_q + 2'd1;
					end
				end
				ST_EMIT: if (!out_v_q || row_ready) begin
					out_v_q <= 1'b1;
					out_q.row <= k_q;
					out_q.c0 <= 32'(rows_q[k_q][0]);
					out_q.c1 <= 32'(rows_q[k_q][1]);
					out_q.c2 <= 32'(rows_q[k_q][2]);
					out_q.c3 <= degen_q ? 32'sd0 : t_q;
					out_q.degen <= degen_q;
					out_q.last <= (k_q == 2'd2);
					st_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (k_q == 2'd2) st_q <= ST_IDLE;
					else begin
						k_q <= k_q + 2'd1; step_q <= 2'd0; acc_q <= '0;
						st_q <= degen_q ? ST_EMIT : ST_DOT;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/look_at_view_matrix_core.sv
// top level of the look-at view matrix core
// back end: each item passes through an iterative square root and a bit-serial
// restoring divider, after small vectors are shifted up; an item with a zero-length
// vector skips them and gives all-zero rows
// throughput: one item per back-end pass, three result rows per item; the front
// queue holds two items so input is taken while the back end works
// reset: arst_n clears queue and sequencer control; payload is not reset
`default_nettype none
module look_at_view_matrix_core import lav_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z, upv_x, upv_y, upv_z
	input  wire logic [287:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// row_index, col0, col1, col2, col3, then zero fill
	output logic [135:0]      m_tdata,
	output logic              m_tlast,
	// degenerate
	output logic              m_tuser
);
	lav_job_t fj, qj;
	logic     qv, qr;
	lav_row_t r;

	// front end: unpack and form the forward difference
	always_comb begin
		fj.ex = s_tdata[31:0];   fj.ey = s_tdata[63:32];  fj.ez = s_tdata[95:64];
		fj.dx = 33'($signed(s_tdata[127:96]))  - 33'($signed(s_tdata[31:0]));
		fj.dy = 33'($signed(s_tdata[159:128])) - 33'($signed(s_tdata[63:32]));
		fj.dz = 33'($signed(s_tdata[191:160])) - 33'($signed(s_tdata[95:64]));
		fj.ux = s_tdata[223:192]; fj.uy = s_tdata[255:224]; fj.uz = s_tdata[287:256];
	end

	lav_queue u_q (.clk, .arst_n, .wr_valid(s_tvalid), .wr_ready(s_tready),
		.wr_data(fj), .rd_valid(qv), .rd_ready(qr), .rd_data(qj));

	lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clk, .arst_n, .job_valid(qv),
		.job_ready(qr), .job(qj), .row_valid(m_tvalid), .row_ready(m_tready),
		.row_out(r));

	assign m_tdata = {6'd0, r.c3, r.c2, r.c1, r.c0, r.row};
	assign m_tlast = r.last;
	assign m_tuser = r.degen;
endmodule
`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the look-at view matrix core
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import lav_pkg::*;

	localparam int FB = 16;
	localparam int LAT = 6 * (FB + 33) + 160;
	localparam longint LIMIT = 4000000;

	typedef struct {
		logic [1:0]  row;
		logic [31:0] c0, c1, c2, c3;
		logic        degen;
		logic        last;
	} view_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         m_tlast;
	logic         m_tuser;

	view_row_t    rows_due[$];
	int           errors = 0;
	int           rows_seen = 0;
	int           items_sent = 0;
	int           degen_seen = 0;
	int           tx_idle = 0;
	int           rx_idle = 0;
	bit           rx_hold = 0;
	longint       cycles = 0;

	look_at_view_matrix_core #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	// clock and cycle limit
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("FAIL");
			$finish;
		end
	end

	// predictor helpers
	function automatic longint unsigned isqrt64(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint rnd_shift(longint x);
		longint unsigned m;
		m = (magn(x) + (64'd1 << (FB - 1))) >> FB;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// unit vector by shared scaling, rounded division by the root
	function automatic bit unit_of(input longint a[3], output longint u[3]);
		longint unsigned m[3], mx, s, r, q;
		mx = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magn(a[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) return 0;
		while (mx >= (64'd1 << 31)) begin
			for (int i = 0; i < 3; i++) m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) m[i] <<= 1;
			mx <<= 1;
		end
		for (int i = 0; i < 3; i++) s += m[i] * m[i];
		r = isqrt64(s);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + r / 2) / r;
			u[i] = a[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic void cross_of(input longint a[3], input longint b[3],
			output longint c[3]);
		c[0] = clamp32(rnd_shift(a[1] * b[2] - a[2] * b[1]));
		c[1] = clamp32(rnd_shift(a[2] * b[0] - a[0] * b[2]));
		c[2] = clamp32(rnd_shift(a[0] * b[1] - a[1] * b[0]));
	endfunction

	// expected view rows for one item
	task automatic predict_view(input logic [287:0] d);
		longint eye[3], dif[3], upv[3], f[3], u[3], m[3][3], t, dot;
		bit ok;
		view_row_t r;
		for (int i = 0; i < 3; i++) begin
			eye[i] = longint'($signed(d[32*i +: 32]));
			dif[i] = longint'($signed(d[32*(i+3) +: 32])) - eye[i];
			upv[i] = longint'($signed(d[32*(i+6) +: 32]));
		end
		ok = unit_of(dif, f);
		if (ok) ok = unit_of(upv, u);
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++) m[k][i] = 0;
		if (ok) begin
			cross_of(f, u, m[0]);
			cross_of(m[0], f, m[1]);
			for (int i = 0; i < 3; i++) m[2][i] = -f[i];
		end
		for (int k = 0; k < 3; k++) begin
			t = 0;
			if (ok) begin
				dot = m[k][0] * eye[0] + m[k][1] * eye[1] + m[k][2] * eye[2];
				t = clamp32(-rnd_shift(dot));
			end
			r.row = k[1:0];
			r.c0 = m[k][0][31:0];
			r.c1 = m[k][1][31:0];
			r.c2 = m[k][2][31:0];
			r.c3 = t[31:0];
			r.degen = !ok;
			r.last = (k == 2);
			rows_due.push_back(r);
		end
	endtask

	// receiver: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
		end
	end

	// compare every accepted row with the oldest expectation
	always @(posedge clk) begin
		view_row_t e;
		if (arst_n && m_tvalid && m_tready) begin
			rows_seen++;
			if (m_tuser) degen_seen++;
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected row %h", $time, m_tdata);
				errors++;
			end else begin
				e = rows_due.pop_front();
				if (m_tdata[1:0] !== e.row || m_tdata[33:2] !== e.c0 ||
						m_tdata[65:34] !== e.c1 || m_tdata[97:66] !== e.c2 ||
						m_tdata[129:98] !== e.c3 || m_tuser !== e.degen ||
						m_tlast !== e.last || m_tdata[135:130] !== 6'd0) begin
					$display("%0t: expected row %0d %h %h %h %h dg %b lst %b",
						$time, e.row, e.c0, e.c1, e.c2, e.c3, e.degen, e.last);
					$display("%0t: actual   row %0d %h %h %h %h dg %b lst %b",
						$time, m_tdata[1:0], m_tdata[33:2], m_tdata[65:34],
						m_tdata[97:66], m_tdata[129:98], m_tuser, m_tlast);
					errors++;
				end
			end
		end
	end

	// offer one item, with random gaps before it
	task automatic send_item(input logic [287:0] d);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_view(d);
		items_sent++;
	endtask

	// drop valid between bursts
	task automatic tx_pause();
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(65536 * 4) - 65536 * 2;
			2: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
			3: return 32'h8000_0000;
			4: return 32'h7fff_ffff;
			default: return 32'($urandom_range(200)) - 100;
		endcase
	endfunction

	function automatic logic [287:0] rnd_item();
		logic [287:0] d;
		for (int i = 0; i < 9; i++) d[32*i +: 32] = rnd_coord();
		if ($urandom_range(19) == 0) d[191:96] = d[95:0];
		if ($urandom_range(19) == 0) d[287:192] = '0;
		return d;
	endfunction

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MN = 32'h8000_0000;
	localparam logic [31:0] MX = 32'h7fff_ffff;
	localparam int NDIR = 12;
	// rows: up z,y,x, target z,y,x, eye z,y,x
	logic [287:0] dir_tab [NDIR] = '{
		{32'd0, ONE, 32'd0, -ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		{32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		{32'd0, 32'd0, 32'd0, -ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		{32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, ONE, 32'd0, 32'd0},
		{MX, MX, MX, MN, MN, MN, MX, MX, MX},
		{MN, MN, MN, MX, MX, MX, MN, MN, MN},
		{32'd0, ONE, 32'd0, MN, MN, MN, MX, MX, MX},
		{32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
		{MX, MN, MX, MN, MX, MN, MX, MN, MX},
		{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0, 32'd0,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
		{32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hedcb_a987,
			32'h0f0f_0f0f, 32'hf0f0_f0f0, MX, 32'd0, MN},
		{MN, MN, MN, 32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 32'd7}
	};

	// spots the zero-length case, which gives all-zero rows
	function automatic bit zero_case(logic [287:0] d);
		return d[95:0] == d[191:96] || d[287:192] == '0;
	endfunction

	// stimulus
	initial begin
		s_tvalid = 0;
		s_tdata = '0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part; degenerate predictions also checked
		for (int n = 0; n < NDIR; n++) begin
			if (zero_case(dir_tab[n]) && rows_due.size() == 0) begin
				send_item(dir_tab[n]);
				if (rows_due[0].degen !== 1 || rows_due[0].c3 !== 0) begin
					$display("%0t: expected degenerate zero rows", $time);
					errors++;
				end
			end else begin
				send_item(dir_tab[n]);
			end
		end
		tx_pause();

		// long receiver hold-off while items keep coming
		fork
			begin
				rx_hold = 1;
				repeat (3 * LAT) @(posedge clk);
				rx_hold = 0;
			end
			for (int n = 0; n < 6; n++) send_item(rnd_item());
		join
		tx_pause();

		// random items over the three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = ph == 0 ? 22 : ph == 1 ? 84 : 0;
			rx_idle = ph == 0 ? 84 : ph == 1 ? 22 : 0;
			for (int n = 0; n < 32; n++) send_item(rnd_item());
		end
		tx_pause();

		while (rows_due.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
		$display("covered %0d items and %0d rows, %0d of them degenerate",
			items_sent, rows_seen, degen_seen);
		$display("directed extremes, zero-length and parallel vectors, random stalls");
		if (errors == 0 && rows_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

>>> look_at_view_matrix_core.f
design/lav_pkg.sv
design/lav_queue.sv
design/lav_back.sv
design/look_at_view_matrix_core.sv
dv/testbench.sv
